// ===== hdl/circular_queue_with_rear_removal_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circular queue
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_REAR_REMOVAL_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_REAR_REMOVAL_MACROS_SVH

// expr must never hold while out of reset
`define CQRR_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("queue check failed: forbidden condition seen");

// cond implies prop (prop may be a sequence with a fixed delay)
`define CQRR_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> prop) \
		else $error("queue check failed: implication violated");

`endif

// ===== hdl/cqrr_pkg.sv =====
// ----------------------------------------------------------------------------
// cqrr_pkg
// Shared codes and field widths of the circular queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cqrr_pkg;

	localparam int FIELD_W  = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH      = 2'd0,
		ACT_POP_FRONT = 2'd1,
		ACT_POP_REAR  = 2'd2,
		ACT_CLEAR     = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_FETCH = 1'b1
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/cqrr_mem.sv =====
// ----------------------------------------------------------------------------
// cqrr_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cqrr_mem #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  wire logic [DATA_WIDTH-1:0]         wr_data,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic      [DATA_WIDTH-1:0]         rd_data_q
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cqrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cqrr_ctrl
// Pointer/count update, cached end values, fetch sequencing, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cqrr_ctrl #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [cqrr_pkg::ACTION_W-1:0]        action,
	input  wire logic signed [cqrr_pkg::FIELD_W-1:0]  push_value,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [cqrr_pkg::FIELD_W-1:0]       taken_value,
	output logic [cqrr_pkg::STATUS_W-1:0]             status,
	output logic [cqrr_pkg::COUNT_W-1:0]              entry_count,
	output logic signed [cqrr_pkg::FIELD_W-1:0]       front_value,
	output logic signed [cqrr_pkg::FIELD_W-1:0]       rear_value,
	// slot memory
	output logic                                      wr_en,
	output logic [$clog2(DEPTH)-1:0]                  wr_addr,
	output logic [DATA_WIDTH-1:0]                     wr_data,
	output logic                                      rd_en,
	output logic [$clog2(DEPTH)-1:0]                  rd_addr,
	input  wire logic [DATA_WIDTH-1:0]                rd_data_q
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int FW = cqrr_pkg::FIELD_W;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	cqrr_pkg::state_t      state_q, state_n;
	logic [AW-1:0]         head_q, tail_q, head_n, tail_n;
	logic [CW-1:0]         count_q, count_n;
	logic [DATA_WIDTH-1:0] front_q, rear_q, front_n, rear_n;
	logic [DATA_WIDTH-1:0] push_data;
	logic [DATA_WIDTH-1:0] taken_n;
	cqrr_pkg::status_t     status_n;
	logic                  wr_req, rd_req, fix_front_n, fix_front_q;
	logic [AW-1:0]         rd_addr_n;
	logic                  accept;

	logic                  out_valid_q;
	logic [FW-1:0]         taken_q, front_out_q, rear_out_q;
	logic [cqrr_pkg::STATUS_W-1:0] status_q;
	logic [cqrr_pkg::COUNT_W-1:0]  count_out_q;

	assign push_data = DATA_WIDTH'($unsigned(push_value));
	assign accept    = in_valid && !in_stall;

	// action decode
	always_comb begin
		head_n      = head_q;
		tail_n      = tail_q;
		count_n     = count_q;
		front_n     = front_q;
		rear_n      = rear_q;
		taken_n     = '0;
		status_n    = cqrr_pkg::STATUS_OK;
		wr_req      = 1'b0;
		rd_req      = 1'b0;
		rd_addr_n   = head_q;
		fix_front_n = 1'b0;
		unique case (cqrr_pkg::action_t'(action))
			cqrr_pkg::ACT_PUSH: begin
				if (count_q == CW'(DEPTH)) begin
					status_n = cqrr_pkg::STATUS_FULL;
				end else begin
					wr_req  = 1'b1;
					tail_n  = ptr_next(tail_q);
					count_n = count_q + CW'(1);
					rear_n  = push_data;
					if (count_q == '0) begin
						front_n = push_data;
					end
				end
			end
			cqrr_pkg::ACT_POP_FRONT: begin
				if (count_q == '0) begin
					status_n = cqrr_pkg::STATUS_EMPTY;
				end else begin
					taken_n = front_q;
					head_n  = ptr_next(head_q);
					count_n = count_q - CW'(1);
					if (count_q > CW'(1)) begin
						rd_req      = 1'b1;
						rd_addr_n   = ptr_next(head_q);
						fix_front_n = 1'b1;
					end
				end
			end
			cqrr_pkg::ACT_POP_REAR: begin
				if (count_q == '0) begin
					status_n = cqrr_pkg::STATUS_EMPTY;
				end else begin
					taken_n = rear_q;
					tail_n  = ptr_prev(tail_q);
					count_n = count_q - CW'(1);
					if (count_q > CW'(1)) begin
						rd_req    = 1'b1;
						rd_addr_n = ptr_prev(ptr_prev(tail_q));
					end
				end
			end
			cqrr_pkg::ACT_CLEAR: begin
				head_n  = '0;
				tail_n  = '0;
				count_n = '0;
			end
			default: begin
				status_n = cqrr_pkg::STATUS_OK;
			end
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cqrr_pkg::ST_IDLE: begin
				if (accept && rd_req) begin
					state_n = cqrr_pkg::ST_FETCH;
				end
			end
			cqrr_pkg::ST_FETCH: begin
				state_n = cqrr_pkg::ST_IDLE;
			end
			default: begin
				state_n = cqrr_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		unique case (state_q)
			cqrr_pkg::ST_IDLE:  in_stall = out_valid_q && out_stall;
			cqrr_pkg::ST_FETCH: in_stall = 1'b1;
			default:            in_stall = 1'b1;
		endcase
	end

	assign wr_en   = accept && wr_req;
	assign wr_addr = tail_q;
	assign wr_data = push_data;
	assign rd_en   = accept && rd_req;
	assign rd_addr = rd_addr_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqrr_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
		end
	end

	// cached end values; refreshed from the memory in the fetch cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q     <= front_n;
			rear_q      <= rear_n;
			fix_front_q <= fix_front_n;
		end else if (state_q == cqrr_pkg::ST_FETCH) begin
			if (fix_front_q) begin
				front_q <= rd_data_q;
			end else begin
				rear_q <= rd_data_q;
			end
		end
	end

	// result register: set when a result is complete, held while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (accept && !rd_req) || state_q == cqrr_pkg::ST_FETCH ||
				(out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taken_q     <= FW'(taken_n);
			status_q    <= status_n;
			count_out_q <= cqrr_pkg::COUNT_W'(count_n);
			front_out_q <= (count_n != '0) ? FW'(front_n) : '0;
			rear_out_q  <= (count_n != '0) ? FW'(rear_n) : '0;
		end else if (state_q == cqrr_pkg::ST_FETCH) begin
			if (fix_front_q) begin
				front_out_q <= FW'(rd_data_q);
			end else begin
				rear_out_q <= FW'(rd_data_q);
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign taken_value = taken_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign front_value = front_out_q;
	assign rear_value  = rear_out_q;

endmodule

`default_nettype wire

// ===== hdl/circular_queue_with_rear_removal.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_rear_removal
// Ring-buffer queue with enqueue, front dequeue, rear removal and clear.
// ----------------------------------------------------------------------------
// One input beat carries one action and yields exactly one result beat with
// the removed value, a status (ok, empty on removal, full so the push was
// dropped), the entry count and the front and rear values (0 when empty).
// A push, a clear, any refused action, or a removal that leaves the queue
// empty goes straight to the result register; a removal that leaves one or
// more entries first passes a fetch state, as the new front or rear value
// is read from the slot memory via its single read port with registered
// read data. The result sits in an output register, so a new input beat is
// taken while the previous result is drained; input is stalled in the fetch
// state and while out_stall holds that register. Slot contents are not
// cleared at reset or by a clear action; only live entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_queue_with_rear_removal_macros.svh"

module circular_queue_with_rear_removal #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// action beats
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [cqrr_pkg::ACTION_W-1:0]        action,
	input  wire logic signed [cqrr_pkg::FIELD_W-1:0]  push_value,
	// result beats
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [cqrr_pkg::FIELD_W-1:0]       taken_value,
	output logic [cqrr_pkg::STATUS_W-1:0]             status,
	output logic [cqrr_pkg::COUNT_W-1:0]              entry_count,
	output logic signed [cqrr_pkg::FIELD_W-1:0]       front_value,
	output logic signed [cqrr_pkg::FIELD_W-1:0]       rear_value
);

	localparam int AW = $clog2(DEPTH);

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data_q;

	// pointers, count, cached ends and result register
	cqrr_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.taken_value (taken_value),
		.status      (status),
		.entry_count (entry_count),
		.front_value (front_value),
		.rear_value  (rear_value),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data_q   (rd_data_q)
	);

	// slot storage
	cqrr_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	// a beat either pushes or fetches, never both
	`CQRR_ASSERT_NEVER(a_no_rw_same_beat, clk, arst_n, wr_en && rd_en)
	// a fetch is followed by its result once the fetch state has passed
	`CQRR_ASSERT_IMPLY(a_fetch_to_result, clk, arst_n, rd_en, ##2 out_valid)
	// a dropped push reports a full queue
	`CQRR_ASSERT_IMPLY(a_full_count, clk, arst_n, out_valid && status == cqrr_pkg::STATUS_FULL, entry_count == cqrr_pkg::COUNT_W'(DEPTH))
	// a refused removal takes nothing and leaves the queue empty
	`CQRR_ASSERT_IMPLY(a_empty_result, clk, arst_n, out_valid && status == cqrr_pkg::STATUS_EMPTY, (taken_value == '0 && entry_count == '0))

endmodule

`default_nettype wire

// ===== tb/circular_queue_with_rear_removal_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_with_rear_removal_tb
// Self-checking bench for the ring-buffer queue. A driver feeds action beats
// from a pre-built list and a monitor takes result beats. Both sides idle or
// stall at random. Every accepted action runs through a mirror of the queue
// that predicts the result beat. The monitor compares each result beat,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module circular_queue_with_rear_removal_tb;

	localparam int SLOT_COUNT  = 16;     // matches the default DEPTH of the block
	localparam int TOTAL_BEATS = 1050;
	localparam int MAX_IDLE    = 16;
	localparam int DRAIN_TAIL  = 8;      // cycles kept after the last result

	// One pending action beat, with the idle cycles the driver waits before it.
	typedef struct {
		cqrr_pkg::action_t                 act;
		logic [cqrr_pkg::FIELD_W-1:0]      value;
		int unsigned                       gap;
	} action_beat_t;

	// One predicted result beat.
	typedef struct {
		logic [cqrr_pkg::FIELD_W-1:0]      taken;
		cqrr_pkg::status_t                 status;
		logic [cqrr_pkg::COUNT_W-1:0]      count;
		logic [cqrr_pkg::FIELD_W-1:0]      front;
		logic [cqrr_pkg::FIELD_W-1:0]      rear;
	} queue_result_t;

	// Shape of a stretch of random stimulus.
	typedef enum int {
		RUN_FILL,   // mostly pushes: drives the queue to full and wraps the rear
		RUN_DRAIN,  // mostly removals: drives the queue to empty
		RUN_MIXED,  // pushes and removals balanced
		RUN_NOISE   // any action, clears included, at equal odds
	} run_kind_t;

	// Idle pattern on the action side for one stretch.
	typedef enum int {
		GAPS_NONE,
		GAPS_SHORT,
		GAPS_WIDE
	} gap_kind_t;

	logic                                clk;
	logic                                arst_n = 1'b0;

	logic                                in_valid = 1'b0;
	logic                                in_stall;
	cqrr_pkg::action_t                   action = cqrr_pkg::ACT_PUSH;
	logic signed [cqrr_pkg::FIELD_W-1:0] push_value = '0;

	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [cqrr_pkg::FIELD_W-1:0] taken_value;
	logic [cqrr_pkg::STATUS_W-1:0]       status;
	logic [cqrr_pkg::COUNT_W-1:0]        entry_count;
	logic signed [cqrr_pkg::FIELD_W-1:0] front_value;
	logic signed [cqrr_pkg::FIELD_W-1:0] rear_value;

	circular_queue_with_rear_removal dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.push_value  (push_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.taken_value (taken_value),
		.status      (status),
		.entry_count (entry_count),
		.front_value (front_value),
		.rear_value  (rear_value)
	);

	action_beat_t  pending_beats[$];
	queue_result_t awaited_results[$];
	int unsigned   mismatch_count = 0;

	// Mirror of the queue state. Slots that were never written are never read.
	logic [cqrr_pkg::FIELD_W-1:0] mirror_slots[SLOT_COUNT];
	int unsigned                  mirror_head  = 0;
	int unsigned                  mirror_tail  = 0;
	int unsigned                  mirror_count = 0;

	// Driver and monitor bookkeeping
	int unsigned   idle_count  = 0;
	int unsigned   stall_left  = 0;
	int unsigned   stall_draw  = 0;
	logic          stall_quiet = 1'b0;
	queue_result_t want;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Queue mirror: applies one action and returns the result beat it causes.
	// ------------------------------------------------------------------------
	function automatic queue_result_t apply_action(cqrr_pkg::action_t act,
			logic [cqrr_pkg::FIELD_W-1:0] value);
		queue_result_t r;
		r.taken  = '0;
		r.status = cqrr_pkg::STATUS_OK;
		case (act)
			cqrr_pkg::ACT_PUSH: begin
				// full: the value is dropped and nothing moves
				if (mirror_count == SLOT_COUNT) begin
					r.status = cqrr_pkg::STATUS_FULL;
				end else begin
					mirror_slots[mirror_tail] = value;
					mirror_tail = (mirror_tail + 1) % SLOT_COUNT;
					mirror_count++;
				end
			end
			cqrr_pkg::ACT_POP_FRONT: begin
				if (mirror_count == 0) begin
					r.status = cqrr_pkg::STATUS_EMPTY;
				end else begin
					r.taken = mirror_slots[mirror_head];
					mirror_head = (mirror_head + 1) % SLOT_COUNT;
					mirror_count--;
				end
			end
			cqrr_pkg::ACT_POP_REAR: begin
				// the rear steps back, wrapping from slot 0 to the last slot
				if (mirror_count == 0) begin
					r.status = cqrr_pkg::STATUS_EMPTY;
				end else begin
					mirror_tail = (mirror_tail + SLOT_COUNT - 1) % SLOT_COUNT;
					r.taken = mirror_slots[mirror_tail];
					mirror_count--;
				end
			end
			default: begin
				// clear: indices go home, slot contents stay but are dead
				mirror_head  = 0;
				mirror_tail  = 0;
				mirror_count = 0;
			end
		endcase
		r.count = mirror_count[cqrr_pkg::COUNT_W-1:0];
		if (mirror_count != 0) begin
			r.front = mirror_slots[mirror_head];
			r.rear  = mirror_slots[(mirror_tail + SLOT_COUNT - 1) % SLOT_COUNT];
		end else begin
			r.front = '0;
			r.rear  = '0;
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		$display("%0t ns  mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic int unsigned draw_gap(gap_kind_t kind);
		case (kind)
			GAPS_NONE:  return 0;
			GAPS_SHORT: return $urandom_range(0, 2);
			default:    return $urandom_range(0, MAX_IDLE);
		endcase
	endfunction

	// Extremes now and then, otherwise every bit at random.
	function automatic logic [cqrr_pkg::FIELD_W-1:0] draw_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_beat(cqrr_pkg::action_t act, logic [cqrr_pkg::FIELD_W-1:0] value,
			int unsigned gap);
		action_beat_t b;
		b.act   = act;
		b.value = value;
		b.gap   = gap;
		pending_beats.push_back(b);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus list, reset, and end of run
	// ------------------------------------------------------------------------
	initial begin : run_control
		run_kind_t         run;
		gap_kind_t         gaps;
		int unsigned       run_len;
		int unsigned       roll;
		cqrr_pkg::action_t act;

		// Directed opening: removals and clear on an empty queue
		add_beat(cqrr_pkg::ACT_POP_FRONT, 32'hDEAD_BEEF, 0);
		add_beat(cqrr_pkg::ACT_POP_REAR, 32'h1234_5678, 0);
		add_beat(cqrr_pkg::ACT_CLEAR, '0, draw_gap(GAPS_WIDE));
		// fill to the brim with extremes and bit patterns in the mix
		add_beat(cqrr_pkg::ACT_PUSH, 32'h8000_0000, 0);
		add_beat(cqrr_pkg::ACT_PUSH, 32'h7FFF_FFFF, 0);
		add_beat(cqrr_pkg::ACT_PUSH, 32'h0000_0000, 1);
		add_beat(cqrr_pkg::ACT_PUSH, 32'hFFFF_FFFF, 0);
		add_beat(cqrr_pkg::ACT_PUSH, 32'hAAAA_AAAA, 0);
		add_beat(cqrr_pkg::ACT_PUSH, 32'h5555_5555, 3);
		repeat (SLOT_COUNT - 6)
			add_beat(cqrr_pkg::ACT_PUSH, $urandom, draw_gap(GAPS_SHORT));
		// push into a full queue is dropped
		add_beat(cqrr_pkg::ACT_PUSH, 32'h0BAD_F00D, 0);
		// rear removal from slot 0 wraps the rear to the last slot
		add_beat(cqrr_pkg::ACT_POP_REAR, '0, 0);
		add_beat(cqrr_pkg::ACT_POP_FRONT, '0, 0);
		add_beat(cqrr_pkg::ACT_CLEAR, '0, 0);
		add_beat(cqrr_pkg::ACT_POP_FRONT, '0, 0);

		// Random stretches of mostly well-formed traffic with some noise
		while (pending_beats.size() < TOTAL_BEATS) begin
			run     = run_kind_t'($urandom_range(0, 3));
			gaps    = gap_kind_t'($urandom_range(0, 2));
			run_len = $urandom_range(8, 48);
			repeat (run_len) begin
				roll = $urandom_range(0, 99);
				case (run)
					RUN_FILL:
						act = (roll < 75) ? cqrr_pkg::ACT_PUSH :
							(roll < 87) ? cqrr_pkg::ACT_POP_FRONT :
							(roll < 99) ? cqrr_pkg::ACT_POP_REAR : cqrr_pkg::ACT_CLEAR;
					RUN_DRAIN:
						act = (roll < 25) ? cqrr_pkg::ACT_PUSH :
							(roll < 62) ? cqrr_pkg::ACT_POP_FRONT :
							(roll < 99) ? cqrr_pkg::ACT_POP_REAR : cqrr_pkg::ACT_CLEAR;
					RUN_MIXED:
						act = (roll < 48) ? cqrr_pkg::ACT_PUSH :
							(roll < 73) ? cqrr_pkg::ACT_POP_FRONT :
							(roll < 98) ? cqrr_pkg::ACT_POP_REAR : cqrr_pkg::ACT_CLEAR;
					default:
						act = cqrr_pkg::action_t'($urandom_range(0, 3));
				endcase
				add_beat(act, draw_value(), draw_gap(gaps));
			end
		end

		// Reset once, released on a clock edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// all beats handed over, then all results back, then a short tail
		while (pending_beats.size() != 0 || in_valid) @(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Slowest correct run takes about half a millisecond.
	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: an accepted beat is run through the mirror at once; the next
	// beat goes up only after its idle cycles have passed. Valid stays high
	// and the payload stays put while the block stalls.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			idle_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_action(action, push_value));
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_count < pending_beats[0].gap) begin
					in_valid   <= 1'b0;
					idle_count <= idle_count + 1;
				end else begin
					in_valid   <= 1'b1;
					action     <= pending_beats[0].act;
					push_value <= pending_beats[0].value;
					idle_count <= 0;
					void'(pending_beats.pop_front());
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each result beat against the oldest prediction, then
	// draws how many cycles to hold off the next one. Quiet stretches with
	// no stall at all come and go at random.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result beat with no action awaiting it");
				end else begin
					want = awaited_results.pop_front();
					if (taken_value !== want.taken)
						flag_mismatch($sformatf("taken_value %h, want %h",
							taken_value, want.taken));
					if (status !== want.status)
						flag_mismatch($sformatf("status %0d, want %s",
							status, want.status.name()));
					if (entry_count !== want.count)
						flag_mismatch($sformatf("entry_count %0d, want %0d",
							entry_count, want.count));
					if (front_value !== want.front)
						flag_mismatch($sformatf("front_value %h, want %h",
							front_value, want.front));
					if (rear_value !== want.rear)
						flag_mismatch($sformatf("rear_value %h, want %h",
							rear_value, want.rear));
				end
				if ($urandom_range(0, 59) == 0)
					stall_quiet <= ~stall_quiet;
				if (stall_quiet) begin
					stall_left <= 0;
					out_stall  <= 1'b0;
				end else begin
					// stall starts right away and lasts the drawn cycles
					stall_draw = $urandom_range(0, MAX_IDLE);
					stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
					out_stall  <= (stall_draw != 0);
				end
			end else if (stall_left != 0) begin
				// hold off for the drawn number of cycles
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

endmodule
